[rtl/rdf_pkg.sv]
`timescale 1ns / 1ps

package rdf_pkg;

  // Radix mode codes held in the configuration register.
  localparam logic [1:0] MODE_HEX = 2'd0;
  localparam logic [1:0] MODE_OCT = 2'd1;
  localparam logic [1:0] MODE_DEC = 2'd2;

  localparam int VAL_W     = 16;
  localparam int NUM_BCD   = 5;
  localparam int BCD_W     = 4 * NUM_BCD;
  localparam int DD_W      = BCD_W + VAL_W;
  localparam int DD_STAGES = 4;
  localparam int DD_STEPS  = VAL_W / DD_STAGES;
  localparam int MAX_CHARS = 6;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  localparam logic [15:0][7:0] HEX_DIGITS = {
    8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
    8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
  };

  // One request as it moves down the conversion pipeline.
  typedef struct packed {
    logic [DD_W-1:0]  dd;    // BCD digits on top, binary still to shift below
    logic [VAL_W-1:0] val;   // masked value, kept for hex and octal
    logic             word;
    logic [1:0]       mode;
  } rdf_item_t;

  typedef logic [MAX_CHARS-1:0][7:0] rdf_chars_t;

  // A group of shift-and-add-three steps of the binary to BCD conversion.
  function automatic logic [DD_W-1:0] dd_steps(input logic [DD_W-1:0] x);
    logic [DD_W-1:0] t;
    t = x;
    for (int i = 0; i < DD_STEPS; i++) begin
      for (int j = 0; j < NUM_BCD; j++) begin
        if (t[VAL_W + 4*j +: 4] >= 4'd5) begin
          t[VAL_W + 4*j +: 4] = t[VAL_W + 4*j +: 4] + 4'd3;
        end
      end
      t = {t[DD_W-2:0], 1'b0};
    end
    return t;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    return HEX_DIGITS[d];
  endfunction

  function automatic logic [7:0] oct_char(input logic [2:0] d);
    return ASCII_ZERO + {5'd0, d};
  endfunction

  function automatic logic [7:0] dec_char(input logic [3:0] d);
    return ASCII_ZERO + {4'd0, d};
  endfunction

endpackage

[rtl/rdf_dd_stage.sv]
`timescale 1ns / 1ps

module rdf_dd_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_v,
  input  rdf_pkg::rdf_item_t in_item,
  output logic               in_rdy,
  output logic               out_v,
  output rdf_pkg::rdf_item_t out_item,
  input  logic               out_rdy
);
  import rdf_pkg::*;

  logic      v_r;
  rdf_item_t item_r;
  rdf_item_t item_nxt;

  // The stage takes a new request when it is empty or its content moves on.
  assign in_rdy = !v_r || out_rdy;

  always_comb begin
    item_nxt    = in_item;
    item_nxt.dd = dd_steps(in_item.dd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_rdy) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_v) begin
      item_r <= item_nxt;
    end
  end

  assign out_v    = v_r;
  assign out_item = item_r;

endmodule

[rtl/rdf_serializer.sv]
`timescale 1ns / 1ps

module rdf_serializer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_v,
  input  rdf_pkg::rdf_item_t in_item,
  output logic               in_rdy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_ascii_char,
  output logic               out_last
);
  import rdf_pkg::*;

  logic       v_r;
  rdf_chars_t chars_r;
  logic [2:0] rem_r;

  rdf_chars_t ld_chars;
  logic [2:0] ld_cnt;
  logic [NUM_BCD-1:0][3:0] bcd;
  logic [2:0] lz;
  logic [3:0] src;
  logic       last_out;

  // Digits of the converted value, most significant first.
  always_comb begin
    for (int k = 0; k < NUM_BCD; k++) begin
      bcd[k] = in_item.dd[DD_W - 4*(k+1) +: 4];
    end
    if (bcd[0] != 4'd0) begin
      lz = 3'd0;
    end else if (bcd[1] != 4'd0) begin
      lz = 3'd1;
    end else if (bcd[2] != 4'd0) begin
      lz = 3'd2;
    end else if (bcd[3] != 4'd0) begin
      lz = 3'd3;
    end else begin
      lz = 3'd4;
    end
  end

  always_comb begin
    ld_chars = '0;
    ld_cnt   = 3'd1;
    src      = '0;
    case (in_item.mode)
      MODE_HEX: begin
        if (in_item.word) begin
          ld_chars[0] = hex_char(in_item.val[15:12]);
          ld_chars[1] = hex_char(in_item.val[11:8]);
          ld_chars[2] = hex_char(in_item.val[7:4]);
          ld_chars[3] = hex_char(in_item.val[3:0]);
          ld_cnt      = 3'd4;
        end else begin
          ld_chars[0] = hex_char(in_item.val[7:4]);
          ld_chars[1] = hex_char(in_item.val[3:0]);
          ld_cnt      = 3'd2;
        end
      end
      MODE_OCT: begin
        if (in_item.word) begin
          ld_chars[0] = oct_char({2'd0, in_item.val[15]});
          ld_chars[1] = oct_char(in_item.val[14:12]);
          ld_chars[2] = oct_char(in_item.val[11:9]);
          ld_chars[3] = oct_char(in_item.val[8:6]);
          ld_chars[4] = oct_char(in_item.val[5:3]);
          ld_chars[5] = oct_char(in_item.val[2:0]);
          ld_cnt      = 3'd6;
        end else begin
          ld_chars[0] = oct_char(in_item.val[8:6]);
          ld_chars[1] = oct_char(in_item.val[5:3]);
          ld_chars[2] = oct_char(in_item.val[2:0]);
          ld_cnt      = 3'd3;
        end
      end
      default: begin
        for (int k = 0; k < NUM_BCD; k++) begin
          src = 4'(k) + {1'b0, lz};
          if (src < 4'(NUM_BCD)) begin
            ld_chars[k] = dec_char(bcd[src[2:0]]);
          end
        end
        ld_cnt = 3'(NUM_BCD) - lz;
      end
    endcase
  end

  assign last_out = (rem_r == 3'd1);
  assign in_rdy   = !v_r || (out_ready && last_out);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      rem_r <= '0;
    end else if (in_rdy) begin
      v_r <= in_v;
      if (in_v) begin
        rem_r <= ld_cnt;
      end
    end else if (out_ready) begin
      rem_r <= rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      if (in_v) begin
        chars_r <= ld_chars;
      end
    end else if (out_ready) begin
      chars_r <= {8'd0, chars_r[MAX_CHARS-1:1]};
    end
  end

  assign out_valid      = v_r;
  assign out_ascii_char = chars_r[0];
  assign out_last       = last_out;

endmodule

[rtl/radix_digit_formatter.sv]
`timescale 1ns / 1ps

// Formats 8-bit or 16-bit values as ASCII digits, one character per result.
// Input requests arrive on in_valid/in_ready with in_value and in_is_word; a
// byte uses only bits 7..0. Characters leave on out_valid/out_ready, most
// significant first, with out_last high on the final character of a value.
// The radix is set through cfg_wr_en/cfg_wr_data: 0 hex (2 or 4 digits),
// 1 octal (3 or 6 digits), 2 or 3 decimal without leading zeros.
// The first character of a request passes through four stages of binary to
// BCD conversion and then the character buffer. The output gives one
// character per cycle while out_ready is high; the character buffer holds a
// value until its last character is taken, and loads the following value as
// that character leaves. The conversion stages accept a new request in every
// cycle while they drain.
// Reset (rst_n low, synchronous) empties every stage and sets the radix to
// hexadecimal. When the receiver stalls, the current character is held, the
// stages fill up behind it and in_ready falls once no stage can move on.
module radix_digit_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_value,
  input  logic        in_is_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_ascii_char,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);
  import rdf_pkg::*;

  // Radix register; user writes it only while block is idle, not enforced.
  logic [1:0] mode_r;

  // Handshake and payload between the pipeline stages. Index 0 is the input
  // request, index DD_STAGES the request handed to the character buffer.
  logic      stg_v   [DD_STAGES+1];
  logic      stg_rdy [DD_STAGES+1];
  rdf_item_t stg_item[DD_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HEX;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // A byte request has its high bits cleared before conversion, so the BCD
  // result and the octal top digit both see only bits 7..0.
  always_comb begin
    stg_item[0].val  = in_is_word ? in_value : {8'd0, in_value[7:0]};
    stg_item[0].dd   = {{BCD_W{1'b0}}, stg_item[0].val};
    stg_item[0].word = in_is_word;
    stg_item[0].mode = mode_r;
  end

  assign stg_v[0] = in_valid;
  assign in_ready = stg_rdy[0];

  // Binary to BCD conversion, a quarter of the shift steps in each stage.
  for (genvar g = 0; g < DD_STAGES; g++) begin : g_dd
    rdf_dd_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_v     (stg_v[g]),
      .in_item  (stg_item[g]),
      .in_rdy   (stg_rdy[g]),
      .out_v    (stg_v[g+1]),
      .out_item (stg_item[g+1]),
      .out_rdy  (stg_rdy[g+1])
    );
  end

  // Character buffer: builds the digit string and sends it out one by one.
  rdf_serializer u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_v           (stg_v[DD_STAGES]),
    .in_item        (stg_item[DD_STAGES]),
    .in_rdy         (stg_rdy[DD_STAGES]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ascii_char (out_ascii_char),
    .out_last       (out_last)
  );

endmodule
